@@ design/tipm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie insert and prefix match: shared types and constants
// Holds the transaction payload types of the input and result channels and
// the opcode codes used by the block.
// ----------------------------------------------------------------------------
package tipm_pkg;

    // Width of the letter field on both channels.
    localparam int LETTER_W = 5;

    // Opcodes carried with each letter.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // One letter of a word, with its opcode and word marks.
    typedef struct packed {
        logic                opcode;
        logic [LETTER_W-1:0] letter;
        logic                word_start;
        logic                word_end;
    } t_in_item;

    // One result, produced for every accepted letter.
    typedef struct packed {
        logic                matched;
        logic                created;
        logic                pool_full;
        logic [LETTER_W-1:0] letter_out;
        logic                last_out;
    } t_out_item;

endpackage

@@ design/tipm_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie insert and prefix match: valid/ready channel
// Carries one payload per transaction; a transaction completes at a rising
// clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tipm_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/trie_insert_prefix_match_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie insert and prefix match unit
// A 26-ary trie over the letters A to Z, fed one letter per transaction.
// Insert walks or grows the trie; search reports the longest matched prefix.
// ----------------------------------------------------------------------------
// After reset the block clears its child table, one entry per cycle, over
// all MAX_NODES * ALPHABET entries (26624 with the defaults); no letter is
// accepted during that pass. After that, for each letter, the accepting
// cycle reads the child entry of the current node from the synchronous child
// table, the next cycle decides, writes a new child back if one is created,
// and moves the cursor. The next letter starts from that cursor, so no new
// letter is accepted before the last is decided. Every letter yields exactly
// one result, in order, held in an output register until it is taken; a
// waiting result holds off the next letter only if it is still not taken when
// that letter arrives.
module trie_insert_prefix_match_unit #(
    parameter int MAX_NODES = 1024,
    parameter int ALPHABET  = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tipm_chan_if.sink   i_in,
    tipm_chan_if.source o_out
);

    localparam int DEPTH  = MAX_NODES * ALPHABET;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW     = 7;
    localparam logic [AW-1:0] ALPHA_A   = AW'(ALPHABET);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [NW:0]   POOL_SIZE = (NW + 1)'(MAX_NODES);
    localparam logic [CW-1:0] ALPHA_C   = CW'(ALPHABET);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    // Child table: one entry per node and letter, zero means no child.
    logic [NW-1:0] mem [DEPTH];

    t_state                  r_state;
    logic [AW-1:0]           r_clr;
    logic [NW:0]             r_nodes;
    logic [AW-1:0]           r_base;
    logic                    r_stopped;
    logic [AW-1:0]           r_addr;
    logic [NW-1:0]           r_rd;
    logic                    r_op;
    logic [tipm_pkg::LETTER_W-1:0] r_letter;
    logic                    r_last;
    logic                    r_in_range;
    logic                    r_out_valid;
    tipm_pkg::t_out_item     r_out;

    logic                    in_acc;
    logic [AW-1:0]           rd_addr;
    logic                    hit;
    logic                    room;
    logic                    live;
    logic                    create;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [NW-1:0]           mem_wdata;
    logic [NW-1:0]           n_cursor;

    // Input handshake: idle, and the output register empty or draining now.
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;

    // Child entry address of the letter below the current (or root) node.
    assign rd_addr = (i_in.payload.word_start ? '0 : r_base) + AW'(i_in.payload.letter);

    // Decision on the entry read for the latched letter.
    assign hit    = (r_rd != '0);
    assign room   = (r_nodes < POOL_SIZE);
    assign live   = !r_stopped && r_in_range;
    assign create = (r_state == S_LOOK) && live && !hit
                    && (r_op == tipm_pkg::OP_INSERT) && room;
    assign n_cursor = hit ? r_rd : r_nodes[NW-1:0];

    // Memory write port: clearing pass or a newly created child.
    assign mem_we    = (r_state == S_CLEAR) || create;
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : r_nodes[NW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_acc) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Sequencer, trie state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_nodes     <= (NW + 1)'(1);
            r_base      <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A result is loaded at the decision cycle and dropped once taken.
            if (r_state == S_LOOK) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_addr     <= rd_addr;
                        r_op       <= i_in.payload.opcode;
                        r_letter   <= i_in.payload.letter;
                        r_last     <= i_in.payload.word_end;
                        r_in_range <= (CW'(i_in.payload.letter) < ALPHA_C);
                        // A start mark returns to the root and resumes the word.
                        if (i_in.payload.word_start) begin
                            r_base    <= '0;
                            r_stopped <= 1'b0;
                        end
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_out.matched    <= live && hit;
                    r_out.created    <= create;
                    r_out.pool_full  <= live && !hit && (r_op == tipm_pkg::OP_INSERT)
                                        && !room;
                    r_out.letter_out <= r_letter;
                    r_out.last_out   <= r_last;
                    if (!r_stopped) begin
                        if (!r_in_range) begin
                            r_stopped <= 1'b1;
                        end else if (hit || create) begin
                            // Follow the existing child or the new node.
                            r_base <= AW'(n_cursor) * ALPHA_A;
                            if (create) begin
                                r_nodes <= r_nodes + (NW + 1)'(1);
                            end
                        end else begin
                            // A search miss or an exhausted pool ends the word.
                            r_stopped <= 1'b1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

@@ design/tipm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie insert and prefix match: port checker
// Watches the channels of the top level and checks ordering and result
// consistency over time.
// ----------------------------------------------------------------------------
module tipm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input tipm_pkg::t_out_item i_out_item
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_item)))
        else $error("result changed while stalled");

    // One letter is worked on at a time: no transaction on the next cycle.
    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !in_acc)
        else $error("input accepted on two consecutive cycles");

    // Every accepted letter shows its result in the output register after its decision state.
    a_result_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ##1 i_out_valid)
        else $error("result missing after accepted letter");

    // A result reports at most one of match, creation and pool exhaustion.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($countones({i_out_item.matched, i_out_item.created,
                                      i_out_item.pool_full}) <= 1))
        else $error("conflicting result flags");

endmodule

bind trie_insert_prefix_match_unit tipm_checker u_tipm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);

@@ tb/tb_trie_insert_prefix_match_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the trie insert and prefix match unit
// Sends words one letter per transaction, as inserts, searches and malformed
// noise. A behavioral trie in the bench predicts every result, and each
// result is checked in order. Random stalls and gaps are applied on both
// channels. The last phase fills the node pool and keeps going past full.
// ----------------------------------------------------------------------------
module tb_trie_insert_prefix_match_unit;

    localparam int NODE_LIMIT = 1024;
    localparam int ALPHA_SIZE = 26;
    localparam int WORD_MAX   = 12;
    localparam int DICT_SIZE  = 256;
    localparam int LTR_W      = tipm_pkg::LETTER_W;

    typedef logic [WORD_MAX-1:0][LTR_W-1:0] t_word;

    logic i_clk;
    logic i_rst_n;

    tipm_chan_if #(.t_payload(tipm_pkg::t_in_item))  in_ch ();
    tipm_chan_if #(.t_payload(tipm_pkg::t_out_item)) out_ch ();

    trie_insert_prefix_match_unit #(
        .MAX_NODES (NODE_LIMIT),
        .ALPHABET  (ALPHA_SIZE)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Behavioral copy of the trie state.
    logic [9:0]  child_idx [0:NODE_LIMIT*ALPHA_SIZE-1];
    int unsigned nodes_alloc = 1;
    int unsigned cur_node    = 0;
    logic        word_halted = 1'b0;

    // Letters waiting to be sent and results waiting to arrive.
    tipm_pkg::t_in_item  pending_letters [$];
    tipm_pkg::t_out_item expected_verdicts [$];

    // Words inserted so far, reused to build hits for search and insert.
    t_word       dict_words [$];
    int unsigned dict_lens [$];

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned phase_items;
    int unsigned mismatches = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Walks the trie for one letter and returns the result it must produce.
    function automatic tipm_pkg::t_out_item walk_trie(tipm_pkg::t_in_item it);
        tipm_pkg::t_out_item res;
        int unsigned         slot;
        int unsigned         nxt;
        res            = '0;
        res.letter_out = it.letter;
        res.last_out   = it.word_end;
        if (it.word_start) begin
            cur_node    = 0;
            word_halted = 1'b0;
        end
        if (!word_halted) begin
            if (it.letter >= ALPHA_SIZE) begin
                word_halted = 1'b1;
            end else begin
                slot = cur_node * ALPHA_SIZE + it.letter;
                nxt  = child_idx[slot];
                if (nxt != 0) begin
                    res.matched = 1'b1;
                    cur_node    = nxt;
                end else if (it.opcode == tipm_pkg::OP_INSERT) begin
                    if (nodes_alloc < NODE_LIMIT) begin
                        child_idx[slot] = nodes_alloc[9:0];
                        cur_node        = nodes_alloc;
                        nodes_alloc++;
                        res.created = 1'b1;
                    end else begin
                        res.pool_full = 1'b1;
                        word_halted   = 1'b1;
                    end
                end else begin
                    word_halted = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic push_letter(logic op, logic [LTR_W-1:0] ltr, logic first, logic fin);
        tipm_pkg::t_in_item it;
        it.opcode     = op;
        it.letter     = ltr;
        it.word_start = first;
        it.word_end   = fin;
        pending_letters.push_back(it);
        phase_items++;
    endtask

    // Sends a word; now and then a letter is out of range or flips opcode.
    task automatic emit_word(logic op, t_word w, int unsigned len);
        int unsigned          i;
        logic [LTR_W-1:0]     ltr;
        logic                 use_op;
        for (i = 0; i < len; i++) begin
            ltr    = w[i];
            use_op = op;
            if ($urandom_range(99) < 3) ltr = LTR_W'($urandom_range(31, ALPHA_SIZE));
            if ($urandom_range(99) < 3) use_op = ~op;
            push_letter(use_op, ltr, i == 0, i == len - 1);
        end
    endtask

    function automatic t_word fresh_word();
        t_word       w;
        int unsigned i;
        for (i = 0; i < WORD_MAX; i++) w[i] = LTR_W'($urandom_range(ALPHA_SIZE - 1));
        return w;
    endfunction

    task automatic remember_word(t_word w, int unsigned len);
        int unsigned k;
        if (dict_words.size() < DICT_SIZE) begin
            dict_words.push_back(w);
            dict_lens.push_back(len);
        end else begin
            k             = $urandom_range(DICT_SIZE - 1);
            dict_words[k] = w;
            dict_lens[k]  = len;
        end
    endtask

    // Mostly well-formed words with random content, the rest is noise.
    task automatic run_random(int unsigned count);
        int unsigned kind;
        int unsigned k;
        int unsigned len;
        int unsigned n;
        int unsigned i;
        t_word       w;
        phase_items = 0;
        while (phase_items < count) begin
            kind = $urandom_range(99);
            if (dict_words.size() == 0 && kind >= 40 && kind < 85) kind = 0;
            if (kind < 40) begin
                // Fresh insert: mostly new nodes.
                w   = fresh_word();
                len = $urandom_range(8, 1);
                emit_word(tipm_pkg::OP_INSERT, w, len);
                remember_word(w, len);
            end else if (kind < 55) begin
                // Reinsert a known word, maybe extended: matches on insert.
                k   = $urandom_range(dict_words.size() - 1);
                w   = dict_words[k];
                len = dict_lens[k] + $urandom_range(3);
                if (len > WORD_MAX) len = WORD_MAX;
                for (i = dict_lens[k]; i < WORD_MAX; i++)
                    w[i] = LTR_W'($urandom_range(ALPHA_SIZE - 1));
                emit_word(tipm_pkg::OP_INSERT, w, len);
                remember_word(w, len);
            end else if (kind < 85) begin
                // Search a known word: exact, truncated, altered or extended.
                k   = $urandom_range(dict_words.size() - 1);
                w   = dict_words[k];
                len = dict_lens[k];
                case ($urandom_range(3))
                    0: ;
                    1: len = $urandom_range(len, 1);
                    2: w[len-1] = LTR_W'($urandom_range(ALPHA_SIZE - 1));
                    default: begin
                        for (i = len; i < WORD_MAX; i++)
                            w[i] = LTR_W'($urandom_range(ALPHA_SIZE - 1));
                        len = len + $urandom_range(2, 1);
                        if (len > WORD_MAX) len = WORD_MAX;
                    end
                endcase
                emit_word(tipm_pkg::OP_SEARCH, w, len);
            end else if (kind < 92) begin
                emit_word(tipm_pkg::OP_SEARCH, fresh_word(), $urandom_range(6, 1));
            end else begin
                // Noise: any field value, marks in any order.
                n = $urandom_range(4, 1);
                for (i = 0; i < n; i++)
                    push_letter(1'($urandom_range(1)), LTR_W'($urandom_range(31)),
                                1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic drain_letters();
        while (pending_letters.size() != 0) @(posedge i_clk);
    endtask

    // Driver: holds a presented transaction until it is taken.
    always @(posedge i_clk) begin
        tipm_pkg::t_in_item taken;
        logic               next_valid;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            next_valid = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                taken = pending_letters.pop_front();
                expected_verdicts.push_back(walk_trie(taken));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_letters.size() != 0
                    && $urandom_range(99) >= src_idle_pct) begin
                next_valid     = 1'b1;
                in_ch.payload <= pending_letters[0];
            end
            in_ch.valid <= next_valid;
        end
    end

    // Monitor: checks each result against the oldest prediction.
    always @(posedge i_clk) begin
        tipm_pkg::t_out_item want;
        tipm_pkg::t_out_item got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result m=%0d c=%0d f=%0d l=%0d e=%0d",
                                 got.matched, got.created, got.pool_full,
                                 got.letter_out, got.last_out);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.matched !== want.matched || got.created !== want.created
                            || got.pool_full !== want.pool_full
                            || got.letter_out !== want.letter_out
                            || got.last_out !== want.last_out) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("ERROR: expected m=%0d c=%0d f=%0d l=%0d e=%0d,",
                                   want.matched, want.created, want.pool_full,
                                   want.letter_out, want.last_out);
                            $display(" got m=%0d c=%0d f=%0d l=%0d e=%0d",
                                     got.matched, got.created, got.pool_full,
                                     got.letter_out, got.last_out);
                        end
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("trie_insert_prefix_match_unit test failed");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        int unsigned i;
        t_word       w;
        for (i = 0; i < NODE_LIMIT * ALPHA_SIZE; i++) child_idx[i] = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        src_idle_pct  = 17;
        snk_idle_pct  = 66;
        i_rst_n       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Search on an empty trie misses.
        push_letter(tipm_pkg::OP_SEARCH, 5'd0, 1'b1, 1'b1);
        // Insert CAT, then CAR sharing the prefix.
        push_letter(tipm_pkg::OP_INSERT, 5'd2, 1'b1, 1'b0);
        push_letter(tipm_pkg::OP_INSERT, 5'd0, 1'b0, 1'b0);
        push_letter(tipm_pkg::OP_INSERT, 5'd19, 1'b0, 1'b1);
        push_letter(tipm_pkg::OP_INSERT, 5'd2, 1'b1, 1'b0);
        push_letter(tipm_pkg::OP_INSERT, 5'd0, 1'b0, 1'b0);
        push_letter(tipm_pkg::OP_INSERT, 5'd17, 1'b0, 1'b1);
        // Search CAB: miss on B, then the stopped word ignores X.
        push_letter(tipm_pkg::OP_SEARCH, 5'd2, 1'b1, 1'b0);
        push_letter(tipm_pkg::OP_SEARCH, 5'd0, 1'b0, 1'b0);
        push_letter(tipm_pkg::OP_SEARCH, 5'd1, 1'b0, 1'b0);
        push_letter(tipm_pkg::OP_SEARCH, 5'd23, 1'b0, 1'b1);
        // Out-of-range letters on insert and search.
        push_letter(tipm_pkg::OP_INSERT, 5'd31, 1'b1, 1'b0);
        push_letter(tipm_pkg::OP_INSERT, 5'd25, 1'b0, 1'b1);
        push_letter(tipm_pkg::OP_SEARCH, 5'd26, 1'b1, 1'b1);
        // A letter without a start mark continues after a word end.
        push_letter(tipm_pkg::OP_INSERT, 5'd25, 1'b1, 1'b1);
        push_letter(tipm_pkg::OP_INSERT, 5'd24, 1'b0, 1'b1);
        // Mixed opcodes on one cursor.
        push_letter(tipm_pkg::OP_SEARCH, 5'd25, 1'b1, 1'b0);
        push_letter(tipm_pkg::OP_INSERT, 5'd16, 1'b0, 1'b0);
        push_letter(tipm_pkg::OP_SEARCH, 5'd23, 1'b0, 1'b1);
        push_letter(tipm_pkg::OP_SEARCH, 5'd25, 1'b1, 1'b0);
        push_letter(tipm_pkg::OP_SEARCH, 5'd24, 1'b0, 1'b1);

        run_random(200);
        drain_letters();
        src_idle_pct = 66;
        snk_idle_pct = 17;
        run_random(200);
        drain_letters();
        src_idle_pct = 0;
        snk_idle_pct = 0;

        // Fill the node pool with long clean words, then run on past full.
        while (nodes_alloc < NODE_LIMIT) begin
            repeat (20) begin
                w = fresh_word();
                for (i = 0; i < WORD_MAX; i++)
                    push_letter(tipm_pkg::OP_INSERT, w[i], i == 0, i == WORD_MAX - 1);
            end
            drain_letters();
        end
        run_random(150);
        drain_letters();

        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("trie_insert_prefix_match_unit test passed");
        end else begin
            $display("trie_insert_prefix_match_unit test failed");
        end
        $finish;
    end

endmodule

@@ trie_insert_prefix_match_unit.f @@
design/tipm_pkg.sv
design/tipm_chan_if.sv
design/trie_insert_prefix_match_unit.sv
design/tipm_checker.sv
tb/tb_trie_insert_prefix_match_unit.sv
